[hdl/medpc_pkg.sv]
// Shared constants and types for the MED predictive pixel codec.
package medpc_pkg;

    localparam int PIX_W = 8;
    localparam int ROW_W = 16;
    localparam int IMG_W_W = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DEFAULT_MAX_WIDTH = 4096;

    localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    typedef struct packed {
        logic             mode;
        logic             restart;
        logic [ROW_W-1:0] row_last;
    } cfg_ctrl_t;

endpackage

[hdl/medpc_cfg.sv]
// Configuration registers: mode, clamped geometry and frame restart pulse.
module medpc_cfg
    import medpc_pkg::*;
#(
    parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    output cfg_ctrl_t                     ctrl,
    output logic [$clog2(MAX_WIDTH)-1:0]  col_last
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = (CW + 1 > IMG_W_W) ? CW + 1 : IMG_W_W;

    logic          mode_reg;
    logic [CW-1:0] col_last_reg;
    logic [CW-1:0] col_last_next;
    logic [ROW_W-1:0] row_last_reg;
    logic [ROW_W-1:0] row_last_next;
    logic          restart_reg;
    logic          restart_next;
    logic [EW-1:0] w_ext;

    assign w_ext = EW'(cfg_data[IMG_W_W-1:0]);

    // zero acts as one, anything past the line store acts as its full depth
    always_comb
    begin
        priority if (w_ext == '0)
            col_last_next = '0;
        else if (w_ext > EW'(MAX_WIDTH))
            col_last_next = CW'(MAX_WIDTH - 1);
        else
            col_last_next = CW'(w_ext - EW'(1));
    end

    assign row_last_next = (cfg_data == '0) ? '0 : cfg_data - ROW_W'(1);

    // any geometry write restarts the frame
    assign restart_next = cfg_we && ((cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_ENCODE;
            col_last_reg <= '0;
            row_last_reg <= '0;
            restart_reg  <= 1'b0;
        end
        else
        begin
            restart_reg <= restart_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MODE:
                        mode_reg <= cfg_data[0];
                    REG_WIDTH:
                        col_last_reg <= col_last_next;
                    REG_HEIGHT:
                        row_last_reg <= row_last_next;
                    default:
                        ;
                endcase
            end
        end
    end

    assign ctrl.mode     = mode_reg;
    assign ctrl.restart  = restart_reg;
    assign ctrl.row_last = row_last_reg;
    assign col_last      = col_last_reg;

endmodule

[hdl/medpc_line_mem.sv]
// Previous-row line store with registered, write-first read.
module medpc_line_mem
    import medpc_pkg::*;
#(
    parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
)
(
    input  logic                          clk,
    input  logic                          we,
    input  logic [$clog2(MAX_WIDTH)-1:0]  waddr,
    input  logic [PIX_W-1:0]              wdata,
    input  logic                          re,
    input  logic [$clog2(MAX_WIDTH)-1:0]  raddr,
    output logic [PIX_W-1:0]              rdata
);

    logic [PIX_W-1:0] mem [MAX_WIDTH];
    logic [PIX_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
        begin
            // one-pixel rows read back the pixel written in the same cycle
            if (we && (waddr == raddr))
                rdata_reg <= wdata;
            else
                rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/medpc_predict.sv]
// Median edge detector prediction and residual / reconstruction arithmetic.
module medpc_predict
    import medpc_pkg::*;
(
    input  logic             mode,
    input  logic [PIX_W-1:0] sample,
    input  logic [PIX_W-1:0] left,
    input  logic [PIX_W-1:0] above,
    input  logic [PIX_W-1:0] upper_left,
    output logic [PIX_W-1:0] result,
    output logic [PIX_W-1:0] pixel
);

    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] hi;
    logic [PIX_W:0]   grad;
    logic [PIX_W-1:0] pred;

    assign lo   = (left < above) ? left : above;
    assign hi   = (left < above) ? above : left;
    assign grad = {1'b0, left} + {1'b0, above} - {1'b0, upper_left};

    always_comb
    begin
        priority if (upper_left >= hi)
            pred = lo;
        else if (upper_left <= lo)
            pred = hi;
        else
            pred = grad[PIX_W-1:0];
    end

    always_comb
    begin
        if (mode == MODE_DECODE)
        begin
            result = sample + pred;
            pixel  = sample + pred;
        end
        else
        begin
            result = sample - pred;
            pixel  = sample;
        end
    end

endmodule

[hdl/med_predictive_pixel_codec_top.sv]
// Top level of the MED predictive pixel codec: item pipeline, counters, neighbors.
//
//  channel | signals                         | moves
//  --------+---------------------------------+-------------------------------
//  in      | in_valid, in_stall, sample_in   | one sample per item
//  out     | out_valid, out_stall,           | one result per input item
//          | sample_out, frame_end           |
//  cfg     | cfg_we, cfg_index, cfg_data     | register write, no handshake
//
// One item per cycle sustained while the output is not stalled; the result register loads
// from the input register when the item advances.
// The line store read for the next column is issued as each item is done,
// so the upper neighbor is ready when the next item arrives.
// Reset clears counters, neighbors and valid flags; data registers and the line store are not cleared.
// A stalled output holds the result; the input stage stalls only when both are full
// and the output is stalled.
module med_predictive_pixel_codec_top
    import medpc_pkg::*;
#(
    parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [PIX_W-1:0]      sample_in,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [PIX_W-1:0]      sample_out,
    output logic                  frame_end,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);

    cfg_ctrl_t        ctrl;
    logic [CW-1:0]    col_last;

    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_sample_reg;
    logic             out_valid_reg;
    logic [PIX_W-1:0] sample_out_reg;
    logic             frame_end_reg;

    logic [CW-1:0]    col_reg;
    logic [CW-1:0]    col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [PIX_W-1:0] left_reg;
    logic [PIX_W-1:0] left_next;
    logic [PIX_W-1:0] ul_reg;
    logic [PIX_W-1:0] ul_next;
    logic             last_next;

    logic             advance;
    logic             accept;
    logic [PIX_W-1:0] above;
    logic [PIX_W-1:0] b_pix;
    logic [PIX_W-1:0] c_pix;
    logic [PIX_W-1:0] result;
    logic [PIX_W-1:0] pixel;

    medpc_cfg #(.MAX_WIDTH(MAX_WIDTH)) u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctrl      (ctrl),
        .col_last  (col_last)
    );

    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    // neighbors above the frame count as zero
    assign b_pix = (row_reg != '0) ? above : '0;
    assign c_pix = (row_reg != '0) ? ul_reg : '0;

    medpc_predict u_predict
    (
        .mode       (ctrl.mode),
        .sample     (s1_sample_reg),
        .left       (left_reg),
        .above      (b_pix),
        .upper_left (c_pix),
        .result     (result),
        .pixel      (pixel)
    );

    always_comb
    begin
        last_next = 1'b0;
        row_next  = row_reg;
        if (col_reg == col_last)
        begin
            col_next  = '0;
            left_next = '0;
            ul_next   = '0;
            if (row_reg == ctrl.row_last)
            begin
                row_next  = '0;
                last_next = 1'b1;
            end
            else
                row_next = row_reg + ROW_W'(1);
        end
        else
        begin
            col_next  = col_reg + CW'(1);
            left_next = pixel;
            ul_next   = above;
        end
    end

    medpc_line_mem #(.MAX_WIDTH(MAX_WIDTH)) u_line_mem
    (
        .clk   (clk),
        .we    (advance),
        .waddr (col_reg),
        .wdata (pixel),
        .re    (advance),
        .raddr (col_next),
        .rdata (above)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            left_reg      <= '0;
            ul_reg        <= '0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (ctrl.restart)
            begin
                col_reg  <= '0;
                row_reg  <= '0;
                left_reg <= '0;
                ul_reg   <= '0;
            end
            else if (advance)
            begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                left_reg <= left_next;
                ul_reg   <= ul_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_sample_reg <= sample_in;
        if (advance)
        begin
            sample_out_reg <= result;
            frame_end_reg  <= last_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign frame_end  = frame_end_reg;

endmodule
